// ===== design/raft_follower_progress_tracker_defines.svh =====
// Assertion macros shared by the follower progress tracker checkers.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef RAFT_FOLLOWER_PROGRESS_TRACKER_DEFINES_SVH
`define RAFT_FOLLOWER_PROGRESS_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RFPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rfpt_pkg.sv =====
// Package for the follower progress tracker: codes, widths and the
// controller/datapath command and status structs. No dependencies.
package rfpt_pkg;

  localparam int WINDOW_DEPTH_DEF = 256;
  localparam int CAP_RESET        = 256;

  localparam int IDX_W     = 64;
  localparam int CMD_W     = 4;
  localparam int CFG_W     = 9;
  localparam int CNT_W     = 9;
  localparam int S_TDATA_W = 3 * IDX_W;
  localparam int M_TDATA_W = 272;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROBE      = 4'd0,
    CMD_REPLICATE  = 4'd1,
    CMD_SNAPSHOT   = 4'd2,
    CMD_SET_NEXT   = 4'd3,
    CMD_ACK        = 4'd4,
    CMD_REJECT     = 4'd5,
    CMD_SNAP_FAIL  = 4'd6,
    CMD_PAUSE      = 4'd7,
    CMD_RESUME     = 4'd8,
    CMD_ADD        = 4'd9,
    CMD_FREE_TO    = 4'd10,
    CMD_FREE_FIRST = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_PROBE     = 2'd0,
    MODE_REPLICATE = 2'd1,
    MODE_SNAPSHOT  = 2'd2
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic cfg_we;
    logic capture;
    logic prep;
    logic exec;
    logic rd_head;
    logic limit_load;
    logic walk_step;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t op;
    logic fill_zero;
    logic walk_hit;
    logic out_busy;
  } ctl_sts_t;

endpackage

// ===== design/rfpt_ctrl.sv =====
// Sequencer for the follower progress tracker: accept, prepare, execute,
// release walk over the in-flight ring, result hand-off. Uses rfpt_pkg.
module rfpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rfpt_pkg::ctl_sts_t sts,
  output rfpt_pkg::ctl_cmd_t cmd
);
  import rfpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EXEC,
    ST_FIRST_RD,
    ST_FIRST_LD,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   idle;

  // nothing is taken while reset is held
  assign idle      = (state == ST_IDLE) && !rst;
  assign cfg_ready = idle;
  assign s_tready  = idle && !cfg_valid;

  always_comb begin
    cmd            = '0;
    cmd.cfg_we     = cfg_ready && cfg_valid;
    cmd.capture    = s_tready && s_tvalid;
    cmd.prep       = (state == ST_PREP);
    cmd.exec       = (state == ST_EXEC);
    cmd.rd_head    = (state == ST_FIRST_RD) || ((state == ST_WALK_RD) && !sts.fill_zero);
    cmd.limit_load = (state == ST_FIRST_LD);
    cmd.walk_step  = (state == ST_WALK_CMP) && sts.walk_hit;
    cmd.out_load   = (state == ST_RESP) && !sts.out_busy;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (cmd.capture) state_next = ST_PREP;
      ST_PREP:     state_next = ST_EXEC;
      ST_EXEC: begin
        case (sts.op)
          CMD_FREE_TO:    state_next = ST_WALK_RD;
          CMD_FREE_FIRST: state_next = sts.fill_zero ? ST_RESP : ST_FIRST_RD;
          default:        state_next = ST_RESP;
        endcase
      end
      ST_FIRST_RD: state_next = ST_FIRST_LD;
      ST_FIRST_LD: state_next = ST_WALK_RD;
      ST_WALK_RD:  state_next = sts.fill_zero ? ST_RESP : ST_WALK_CMP;
      ST_WALK_CMP: state_next = sts.walk_hit ? ST_WALK_RD : ST_RESP;
      ST_RESP:     if (!sts.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/rfpt_datapath.sv =====
// Datapath for the follower progress tracker: index registers, in-flight
// ring memory with registered read, result register. Uses rfpt_pkg.
module rfpt_datapath #(
  parameter int WINDOW_DEPTH = rfpt_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rfpt_pkg::ctl_cmd_t             cmd,
  output rfpt_pkg::ctl_sts_t             sts,
  input  logic [rfpt_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rfpt_pkg::CMD_W-1:0]     s_tuser,
  input  logic [rfpt_pkg::CFG_W-1:0]     cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rfpt_pkg::M_TDATA_W-1:0] m_tdata
);
  import rfpt_pkg::*;

  localparam int AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW       = $clog2(WINDOW_DEPTH + 1);
  localparam int CAP_INIT = (CAP_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : CAP_RESET;

  // captured operands and precomputed increments
  cmd_t             op;
  logic [IDX_W-1:0] idx, cmt, last, limit;
  logic [IDX_W-1:0] idx_p1, last_p1, match_p1, snap_p1;

  // tracked state
  logic [IDX_W-1:0] next_idx, match_idx, commit_idx, snap_idx;
  mode_t            mode;
  logic             pause_flag;
  logic [AW-1:0]    head;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    cap;
  logic             ok, ovf;

  logic [IDX_W-1:0] ring [WINDOW_DEPTH];
  logic [IDX_W-1:0] rd_data;

  logic [FW-1:0]    head_ext, head_plus;
  logic [AW-1:0]    head_adv;
  logic [FW:0]      slot_sum, slot_wrap;
  logic [AW-1:0]    slot;
  logic             full, ring_we;
  logic [FW-1:0]    cap_new;
  logic [IDX_W-1:0] rej_pick, rej_next, probe_next;
  logic             paused, abort;

  assign head_ext  = FW'(head);
  assign head_plus = head_ext + FW'(1);
  assign head_adv  = (head_plus == cap) ? '0 : AW'(head_plus);
  assign slot_sum  = {1'b0, head_ext} + {1'b0, fill};
  assign slot_wrap = (slot_sum >= {1'b0, cap}) ? (slot_sum - {1'b0, cap}) : slot_sum;
  assign slot      = AW'(slot_wrap);
  assign full      = (fill >= cap);
  assign ring_we   = cmd.exec && (op == CMD_ADD) && !full;

  always_comb begin
    if (cfg_data == '0) begin
      cap_new = FW'(1);
    end else if (32'(cfg_data) > 32'(WINDOW_DEPTH)) begin
      cap_new = FW'(WINDOW_DEPTH);
    end else begin
      cap_new = FW'(cfg_data);
    end
  end

  assign rej_pick   = (idx < last_p1) ? idx : last_p1;
  assign rej_next   = (rej_pick == '0) ? IDX_W'(1) : rej_pick;
  assign probe_next = ((mode == MODE_SNAPSHOT) && (snap_p1 > match_p1)) ? snap_p1 : match_p1;

  always_comb begin
    case (mode)
      MODE_PROBE:    paused = pause_flag;
      MODE_SNAPSHOT: paused = 1'b1;
      default:       paused = full;
    endcase
  end
  assign abort = (mode == MODE_SNAPSHOT) && (match_idx >= snap_idx);

  assign sts.op        = op;
  assign sts.fill_zero = (fill == '0);
  assign sts.walk_hit  = (rd_data <= limit);
  assign sts.out_busy  = m_tvalid && !m_tready;

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot] <= idx;
    end
    if (cmd.rd_head) begin
      rd_data <= ring[head];
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= cmd_t'(s_tuser);
      idx   <= s_tdata[IDX_W-1:0];
      cmt   <= s_tdata[2*IDX_W-1:IDX_W];
      last  <= s_tdata[3*IDX_W-1:2*IDX_W];
      limit <= s_tdata[IDX_W-1:0];
    end
    if (cmd.prep) begin
      idx_p1   <= idx + IDX_W'(1);
      last_p1  <= last + IDX_W'(1);
      match_p1 <= match_idx + IDX_W'(1);
      snap_p1  <= snap_idx + IDX_W'(1);
    end
    if (cmd.limit_load) begin
      limit <= rd_data;
    end
  end

  // tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_idx   <= '0;
      match_idx  <= '0;
      commit_idx <= '0;
      snap_idx   <= '0;
      mode       <= MODE_PROBE;
      pause_flag <= 1'b0;
      head       <= '0;
      fill       <= '0;
      cap        <= FW'(CAP_INIT);
      ok         <= 1'b1;
      ovf        <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        cap  <= cap_new;
        head <= '0;
        fill <= '0;
      end
      if (cmd.exec) begin
        ok  <= 1'b1;
        ovf <= 1'b0;
        case (op)
          CMD_PROBE: begin
            pause_flag <= 1'b0;
            snap_idx   <= '0;
            head       <= '0;
            fill       <= '0;
            mode       <= MODE_PROBE;
            next_idx   <= probe_next;
          end
          CMD_REPLICATE: begin
            pause_flag <= 1'b0;
            snap_idx   <= '0;
            head       <= '0;
            fill       <= '0;
            mode       <= MODE_REPLICATE;
            next_idx   <= match_p1;
          end
          CMD_SNAPSHOT: begin
            pause_flag <= 1'b0;
            snap_idx   <= idx;
            head       <= '0;
            fill       <= '0;
            mode       <= MODE_SNAPSHOT;
          end
          CMD_SET_NEXT: next_idx <= idx_p1;
          CMD_ACK: begin
            if (commit_idx < cmt) commit_idx <= cmt;
            ok <= (match_idx < idx);
            if (match_idx < idx) begin
              match_idx  <= idx;
              pause_flag <= 1'b0;
            end
            if (next_idx < idx_p1) next_idx <= idx_p1;
          end
          CMD_REJECT: begin
            if (mode == MODE_REPLICATE) begin
              if (commit_idx < cmt) commit_idx <= cmt;
              if (idx <= match_idx) begin
                ok <= 1'b0;
              end else begin
                next_idx <= match_p1;
              end
            end else if (next_idx != idx_p1) begin
              ok <= 1'b0;
            end else begin
              next_idx   <= rej_next;
              commit_idx <= cmt;
              pause_flag <= 1'b0;
            end
          end
          CMD_SNAP_FAIL: snap_idx   <= '0;
          CMD_PAUSE:     pause_flag <= 1'b1;
          CMD_RESUME:    pause_flag <= 1'b0;
          CMD_ADD: begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              fill <= fill + FW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk_step) begin
        head <= head_adv;
        fill <= fill - FW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, ovf, CNT_W'(fill), ok, abort, paused, snap_idx, mode,
                  commit_idx, match_idx, next_idx};
    end
  end

endmodule

// ===== design/raft_follower_progress_tracker.sv =====
// Follower progress tracker top level: controller plus datapath.
// Depends on rfpt_pkg, rfpt_ctrl and rfpt_datapath.
//
// Tracks a leader's view of one follower: next, matched and committed
// indexes, replication mode, pending snapshot, pause flag and a ring of
// in-flight indexes of up to WINDOW_DEPTH entries (capacity set through the
// cfg channel, clamped to 1..WINDOW_DEPTH; a write empties the window). One
// command per s_axis transaction, one result per command. The block takes one
// command at a time: an accepted command passes the prepare, execute and
// response states; the result register loads in the response state once the
// output is free, and the next command is taken back in idle. The release walk
// (free to, free first) adds a read and a compare state per entry compared,
// plus a read state when the walk finds the window empty, and free first
// fetches the head entry as its limit in a read and a load state; the walk is
// set by the single registered read port of the ring memory. The result sits
// in an output register, so the next command is accepted while the previous
// result waits for m_tready. Both ready outputs stay low during reset. The
// ring is not cleared after reset; only entries inside the held window are
// ever read. Configuration is written only while no command is in flight.
module raft_follower_progress_tracker #(
  parameter int WINDOW_DEPTH = rfpt_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command transaction
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // log_index[63:0], commit_index[127:64], follower_last[191:128]
  input  logic [rfpt_pkg::S_TDATA_W-1:0] s_tdata,
  // command[3:0]
  input  logic [rfpt_pkg::CMD_W-1:0]     s_tuser,
  // result transaction
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // next_index[63:0], match_index[127:64], committed_index[191:128],
  // replica_mode[193:192], pending_snapshot[257:194], is_paused[258],
  // snapshot_abort[259], accepted[260], window_count[269:261],
  // overflow_error[270], zero pad[271]
  output logic [rfpt_pkg::M_TDATA_W-1:0] m_tdata,
  // inflight_capacity write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfpt_pkg::CFG_W-1:0]     cfg_data
);
  import rfpt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rfpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfpt_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== design/rfpt_checker.sv =====
// Port-level checker for the follower progress tracker, bound to the top.
// Depends on rfpt_pkg and raft_follower_progress_tracker_defines.svh.
`include "raft_follower_progress_tracker_defines.svh"

module rfpt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [rfpt_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [rfpt_pkg::CMD_W-1:0]     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rfpt_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [rfpt_pkg::CFG_W-1:0]     cfg_data
);
  import rfpt_pkg::*;

  // held result stays put until taken
  `RFPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // one command in flight: no accept right after an accept
  `RFPT_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "command accepted while busy")

  // snapshot mode always reports paused
  `RFPT_ASSERT_NOW(a_snap_paused, m_tvalid && (m_tdata[193:192] == MODE_SNAPSHOT), m_tdata[258], "snapshot mode not paused")

  // pending snapshot only outside probe and replicate
  `RFPT_ASSERT_NOW(a_snap_clear, m_tvalid && (m_tdata[193:192] != MODE_SNAPSHOT), m_tdata[257:194] == '0, "pending snapshot outside snapshot mode")

  // an overflowing add met a non-empty window
  `RFPT_ASSERT_NOW(a_ovf_count, m_tvalid && m_tdata[270], m_tdata[269:261] != '0, "overflow with empty window")

endmodule

bind raft_follower_progress_tracker rfpt_checker u_rfpt_checker (.*);
